### sv/sliding_window_maximum_core_assert.svh
// Assertion macros for the sliding window maximum core.
// Depends on nothing; included by modules that check their own logic.
`ifndef SLIDING_WINDOW_MAXIMUM_CORE_ASSERT_SVH
`define SLIDING_WINDOW_MAXIMUM_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
`define SWM_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (prop)) else $error(msg);
`define SWM_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) else $error(msg);
`else
`define SWM_ASSERT(lbl, clk_s, rst_s, prop, msg)
`define SWM_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg)
`endif

`endif

### sv/swm_pkg.sv
// Shared types and constants for the sliding window maximum core.
// No dependencies.
package swm_pkg;

  localparam int CFG_W = 7;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

endpackage

### sv/swm_cell.sv
// One cell of the candidate chain: holds a sample of fixed age and its keep flag.
// Depends on swm_pkg.
module swm_cell #(
  parameter int SAMPLE_WIDTH = 32,
  parameter bit HEAD         = 1'b0
) (
  input  logic                           clk,
  input  logic                           rst,
  input  swm_pkg::cell_ctl_t             ctl,
  input  logic                           age_ok,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  input  logic                           in_valid,
  input  logic signed [SAMPLE_WIDTH-1:0] in_value,
  output logic                           valid,
  output logic signed [SAMPLE_WIDTH-1:0] value
);

  logic keep;

  // drop when expired, cleared, or not larger than the arriving sample (head cell: only when expired)
  assign keep = in_valid && age_ok && (HEAD || (!ctl.clear && (in_value > sample)));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.shift) begin
      valid <= keep;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      value <= in_value;
    end
  end

endmodule

### sv/swm_head_sel.sv
// Picks the oldest live cell of the chain, which holds the window maximum.
// No dependencies.
module swm_head_sel #(
  parameter int N = 64,
  parameter int W = 32
) (
  input  logic [N-1:0]        valid,
  input  logic [N-1:0][W-1:0] values,
  output logic [W-1:0]        head
);

  logic [N-1:0] rev;
  logic [N-1:0] rev_oh;
  logic [N-1:0] sel;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      rev[i] = valid[N-1-i];
    end
    rev_oh = rev & (~rev + 1'b1);
    for (int i = 0; i < N; i++) begin
      sel[N-1-i] = rev_oh[i];
    end
  end

  always_comb begin
    head = '0;
    for (int i = 0; i < N; i++) begin
      head = head | ({W{sel[i]}} & values[i]);
    end
  end

endmodule

### sv/sliding_window_maximum_core.sv
// Sliding window maximum: a chain of candidate cells plus head select and output register.
// Depends on swm_pkg, swm_cell, swm_head_sel and sliding_window_maximum_core_assert.svh.
//
//   channel  signals                                 direction
//   in       in_valid, in_ready, sample, first_of_sequence   to core
//   out      out_valid, out_ready, window_max              from core
//   cfg      cfg_we, cfg_wdata (window_size)                to core
//
// An item shifts the chain in the cycle it is taken and is held as pending; the
// head is selected into the output register once that register is free. Up to one item
// per cycle while out_ready is high; out_valid rises only for items that fill the window.
// Reset clears all cells, the sample count and window_size to 1.
// A stalled output holds one pending item; in_ready drops until it can move.
`include "sliding_window_maximum_core_assert.svh"

module sliding_window_maximum_core #(
  parameter int MAX_WINDOW   = 64,
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [swm_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  input  logic                           first_of_sequence,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0] window_max
);

  localparam int WIN_W = $clog2(MAX_WINDOW + 1);
  localparam int CMP_W = (WIN_W > swm_pkg::CFG_W) ? WIN_W : swm_pkg::CFG_W;
  localparam logic [CMP_W-1:0] MAX_EXT = CMP_W'(MAX_WINDOW);

  logic [swm_pkg::CFG_W-1:0] window_size;
  logic [CMP_W-1:0]          wsize_ext;
  logic [WIN_W-1:0]          wsize_eff;

  logic [WIN_W-1:0] samples_seen;
  logic [WIN_W-1:0] samples_seen_next;
  logic [WIN_W-1:0] seen_base;
  logic [WIN_W-1:0] seen_clamp;

  logic pend;
  logic pend_emit;
  logic emit_next;
  logic accept;
  logic out_free;

  swm_pkg::cell_ctl_t ctl;

  logic [MAX_WINDOW-1:0]                         cell_valid;
  logic [MAX_WINDOW-1:0][SAMPLE_WIDTH-1:0]       cell_value;
  logic [MAX_WINDOW-1:0]                         age_ok;
  logic [SAMPLE_WIDTH-1:0]                       head;

  assign wsize_ext = CMP_W'(window_size);
  assign wsize_eff = (wsize_ext > MAX_EXT) ? WIN_W'(MAX_EXT) : WIN_W'(wsize_ext);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= swm_pkg::CFG_W'(1);
    end else if (cfg_we) begin
      window_size <= cfg_wdata;
    end
  end

  assign out_free  = !out_valid || out_ready;
  assign in_ready  = !pend || out_free;
  assign accept    = in_valid && in_ready;
  assign ctl       = '{shift: accept, clear: first_of_sequence};

  always_comb begin
    seen_base         = first_of_sequence ? '0 : samples_seen;
    seen_clamp        = (seen_base > wsize_eff) ? wsize_eff : seen_base;
    samples_seen_next = (seen_clamp < wsize_eff) ? seen_clamp + 1'b1 : seen_clamp;
    emit_next         = (wsize_eff != '0) && (samples_seen_next == wsize_eff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      samples_seen <= '0;
    end else if (accept) begin
      samples_seen <= samples_seen_next;
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < MAX_WINDOW; gi++) begin : g_cell
      assign age_ok[gi] = WIN_W'(gi) < wsize_eff;
      if (gi == 0) begin : g_head
        swm_cell #(
          .SAMPLE_WIDTH(SAMPLE_WIDTH),
          .HEAD        (1'b1)
        ) u_cell (
          .clk     (clk),
          .rst     (rst),
          .ctl     (ctl),
          .age_ok  (age_ok[gi]),
          .sample  (sample),
          .in_valid(1'b1),
          .in_value(sample),
          .valid   (cell_valid[gi]),
          .value   (cell_value[gi])
        );
      end else begin : g_body
        swm_cell #(
          .SAMPLE_WIDTH(SAMPLE_WIDTH),
          .HEAD        (1'b0)
        ) u_cell (
          .clk     (clk),
          .rst     (rst),
          .ctl     (ctl),
          .age_ok  (age_ok[gi]),
          .sample  (sample),
          .in_valid(cell_valid[gi-1]),
          .in_value(cell_value[gi-1]),
          .valid   (cell_valid[gi]),
          .value   (cell_value[gi])
        );
      end
    end
  endgenerate

  swm_head_sel #(
    .N(MAX_WINDOW),
    .W(SAMPLE_WIDTH)
  ) u_head_sel (
    .valid (cell_valid),
    .values(cell_value),
    .head  (head)
  );

  // hold the pending item until the output register can take it
  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= 1'b0;
      pend_emit <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pend && out_free && pend_emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        pend      <= 1'b1;
        pend_emit <= emit_next;
      end else if (pend && out_free) begin
        pend      <= 1'b0;
        pend_emit <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pend && out_free && pend_emit) begin
      window_max <= head;
    end
  end

  `SWM_ASSERT_NEXT(a_newest_kept, clk, rst, accept && (wsize_eff != '0), cell_valid[0],
                   "newest sample not kept")
  `SWM_ASSERT_NEXT(a_seq_clear, clk, rst, accept && first_of_sequence,
                   (cell_valid >> 1) == '0, "window not cleared")
  `SWM_ASSERT(a_emit_has_head, clk, rst, !(pend && pend_emit) || (cell_valid != '0),
              "result with empty chain")

endmodule
